// File: sv/lmcfg_pkg.sv
// Package for the LED matrix chain frame generator.
// Holds the payload structs, the opcode and state enums, and the bit-reverse helper.
// No dependencies.
package lmcfg_pkg;

  localparam logic [3:0] ADDR_NOOP      = 4'h0;
  localparam logic [3:0] ADDR_ROW0      = 4'h1;
  localparam logic [3:0] ADDR_INTENSITY = 4'hA;
  localparam logic [7:0] INTENSITY_MAX  = 8'h0F;

  typedef enum logic [2:0] {
    OP_SET_COLUMN    = 3'd0,
    OP_FLUSH         = 3'd1,
    OP_CLEAR         = 3'd2,
    OP_WRITE_ROW     = 3'd3,
    OP_COMMAND_ALL   = 3'd4,
    OP_SET_INTENSITY = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    CMD_COLUMN,
    CMD_ROWS,
    CMD_FRAMES
  } cmd_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COL_RD,
    ST_COL_WR,
    ST_ROWS,
    ST_FRAMES
  } bk_state_t;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] column;
    logic [2:0] device;
    logic [2:0] row;
    logic [3:0] reg_addr;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [3:0] frame_reg;
    logic [7:0] frame_data;
    logic       end_of_transfer;
    logic       last;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic       clear;
    logic [2:0] dev;
    logic [2:0] bit_pos;
    logic [7:0] value;
    logic [3:0] hit_reg;
    logic       all_hit;
    logic [2:0] target;
  } cmd_t;

  typedef struct packed {
    logic valid;
  } cmd_hs_t;

  function automatic logic [7:0] flip8(input logic [7:0] b);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = b[7-k];
    end
    return r;
  endfunction

endpackage

// File: sv/lmcfg_front.sv
// Front end of the LED matrix chain frame generator.
// Accepts items, classifies them into commands and queues the kept ones two deep.
// Depends on lmcfg_pkg.
module lmcfg_front #(
  parameter int CNT_W = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  lmcfg_pkg::in_item_t  in_item,
  input  logic [CNT_W-1:0]     chain_n,
  output lmcfg_pkg::cmd_hs_t   cmd_hs_o,
  input  logic                 cmd_pop,
  output lmcfg_pkg::cmd_t      cmd
);

  lmcfg_pkg::cmd_t q_mem [2];
  logic            q_wp_r, q_rp_r;
  logic [1:0]      q_cnt_r;
  lmcfg_pkg::cmd_t dec;
  logic            keep;
  logic            q_wr, q_rd;
  logic [3:0]      dev_full;

  assign dev_full = 4'(chain_n) - 4'd1 - {1'b0, in_item.column[5:3]};

  always_comb begin
    dec         = '0;
    dec.value   = in_item.value;
    dec.target  = in_item.device;
    dec.hit_reg = in_item.reg_addr;
    dec.dev     = 3'(dev_full);
    dec.bit_pos = 3'd7 - in_item.column[2:0];
    keep        = 1'b0;
    unique case (in_item.op)
      lmcfg_pkg::OP_SET_COLUMN: begin
        dec.kind = lmcfg_pkg::CMD_COLUMN;
        keep     = 7'(in_item.column) < 7'({chain_n, 3'b000});
      end
      lmcfg_pkg::OP_FLUSH: begin
        dec.kind = lmcfg_pkg::CMD_ROWS;
        keep     = 1'b1;
      end
      lmcfg_pkg::OP_CLEAR: begin
        dec.kind  = lmcfg_pkg::CMD_ROWS;
        dec.clear = 1'b1;
        keep      = 1'b1;
      end
      lmcfg_pkg::OP_WRITE_ROW: begin
        dec.kind    = lmcfg_pkg::CMD_FRAMES;
        dec.hit_reg = {1'b0, in_item.row} + lmcfg_pkg::ADDR_ROW0;
        keep        = 1'b1;
      end
      lmcfg_pkg::OP_COMMAND_ALL: begin
        dec.kind    = lmcfg_pkg::CMD_FRAMES;
        dec.all_hit = 1'b1;
        keep        = 1'b1;
      end
      lmcfg_pkg::OP_SET_INTENSITY: begin
        dec.kind    = lmcfg_pkg::CMD_FRAMES;
        dec.all_hit = 1'b1;
        dec.hit_reg = lmcfg_pkg::ADDR_INTENSITY;
        dec.value   = (in_item.value > lmcfg_pkg::INTENSITY_MAX) ?
                      lmcfg_pkg::INTENSITY_MAX : in_item.value;
        keep        = 1'b1;
      end
      default: begin
        dec.kind = lmcfg_pkg::CMD_FRAMES;
        keep     = 1'b0;
      end
    endcase
  end

  assign in_full        = (q_cnt_r == 2'd2);
  assign q_wr           = in_push && !in_full && keep;
  assign q_rd           = cmd_pop && (q_cnt_r != 2'd0);
  assign cmd_hs_o.valid = (q_cnt_r != 2'd0);
  assign cmd            = q_mem[q_rp_r];

  always_ff @(posedge clk) begin
    if (q_wr) begin
      q_mem[q_wp_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wp_r  <= 1'b0;
      q_rp_r  <= 1'b0;
      q_cnt_r <= 2'd0;
    end else begin
      if (q_wr) begin
        q_wp_r <= ~q_wp_r;
      end
      if (q_rd) begin
        q_rp_r <= ~q_rp_r;
      end
      q_cnt_r <= q_cnt_r + 2'(q_wr) - 2'(q_rd);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3) else $error("command queue count out of range");
  a_drop_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full && !keep && !q_rd) |=> $stable(q_cnt_r))
    else $error("dropped item changed the command queue");
  a_pop_moves: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |=> q_rp_r != $past(q_rp_r)) else $error("pop did not advance queue");
`endif

endmodule

// File: sv/lmcfg_back.sv
// Back end of the LED matrix chain frame generator.
// Holds the shadow row store, runs the frame sequencer and buffers result frames.
// Depends on lmcfg_pkg.
module lmcfg_back #(
  parameter int MAX_DEVICES = 8,
  parameter int CNT_W       = 4,
  parameter int DEV_W       = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [CNT_W-1:0]      chain_n,
  input  lmcfg_pkg::cmd_hs_t    cmd_hs_i,
  output logic                  cmd_pop,
  input  lmcfg_pkg::cmd_t       cmd,
  output logic                  out_empty,
  input  logic                  out_pop,
  output lmcfg_pkg::out_item_t  out_item
);

  localparam logic [2:0] OB_DEPTH = 3'd4;

  lmcfg_pkg::bk_state_t state_r, state_nxt;
  lmcfg_pkg::cmd_t      cmd_r;
  logic [DEV_W-1:0]     dev_r, dev_nxt;
  logic [2:0]           row_r, row_nxt;
  logic [DEV_W-1:0]     last_dev;
  logic                 dev_end, row_end;

  logic [63:0]          mem [MAX_DEVICES];
  logic [MAX_DEVICES-1:0] vld_r;
  logic [63:0]          rd_data_r;
  logic                 rd_vld_r;
  logic                 rd_en, wr_en, clr_vld;
  logic [DEV_W-1:0]     mem_addr;
  logic [63:0]          word_old, word_new;

  logic                 infl_r, infl_eot_r, infl_last_r;
  logic [2:0]           infl_row_r;
  logic                 issue, frm_emit;

  lmcfg_pkg::out_item_t ob_mem [4];
  logic [1:0]           ob_wp_r, ob_rp_r;
  logic [2:0]           ob_cnt_r;
  logic                 ob_wr, ob_rd, space;
  lmcfg_pkg::out_item_t ob_din, frm_item;
  logic                 hit;

  assign last_dev = DEV_W'(chain_n - CNT_W'(1));
  assign dev_end  = (dev_r == last_dev);
  assign row_end  = (row_r == 3'd7);
  assign space    = (ob_cnt_r + {2'b00, infl_r}) < OB_DEPTH;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lmcfg_pkg::ST_IDLE: begin
        if (cmd_hs_i.valid) begin
          unique case (cmd.kind)
            lmcfg_pkg::CMD_COLUMN: state_nxt = lmcfg_pkg::ST_COL_RD;
            lmcfg_pkg::CMD_ROWS:   state_nxt = lmcfg_pkg::ST_ROWS;
            default:               state_nxt = lmcfg_pkg::ST_FRAMES;
          endcase
        end
      end
      lmcfg_pkg::ST_COL_RD: state_nxt = lmcfg_pkg::ST_COL_WR;
      lmcfg_pkg::ST_COL_WR: state_nxt = lmcfg_pkg::ST_IDLE;
      lmcfg_pkg::ST_ROWS: begin
        if (space && dev_end && row_end) begin
          state_nxt = lmcfg_pkg::ST_IDLE;
        end
      end
      lmcfg_pkg::ST_FRAMES: begin
        if (space && dev_end) begin
          state_nxt = lmcfg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lmcfg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    clr_vld  = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    issue    = 1'b0;
    frm_emit = 1'b0;
    mem_addr = dev_r;
    unique case (state_r)
      lmcfg_pkg::ST_IDLE: begin
        cmd_pop = cmd_hs_i.valid;
        clr_vld = cmd_hs_i.valid && (cmd.kind == lmcfg_pkg::CMD_ROWS) && cmd.clear;
      end
      lmcfg_pkg::ST_COL_RD: begin
        rd_en    = 1'b1;
        mem_addr = DEV_W'(cmd_r.dev);
      end
      lmcfg_pkg::ST_COL_WR: begin
        wr_en    = 1'b1;
        mem_addr = DEV_W'(cmd_r.dev);
      end
      lmcfg_pkg::ST_ROWS: begin
        issue = space;
        rd_en = space;
      end
      lmcfg_pkg::ST_FRAMES: begin
        frm_emit = space;
      end
      default: ;
    endcase
  end

  always_comb begin
    dev_nxt = dev_r;
    row_nxt = row_r;
    if (state_r == lmcfg_pkg::ST_IDLE) begin
      dev_nxt = '0;
      row_nxt = '0;
    end else if (issue || frm_emit) begin
      if (dev_end) begin
        dev_nxt = '0;
        row_nxt = row_r + 3'd1;
      end else begin
        dev_nxt = dev_r + DEV_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lmcfg_pkg::ST_IDLE;
      dev_r   <= '0;
      row_r   <= '0;
      infl_r  <= 1'b0;
      vld_r   <= '0;
    end else begin
      state_r <= state_nxt;
      dev_r   <= dev_nxt;
      row_r   <= row_nxt;
      infl_r  <= issue;
      if (clr_vld) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[mem_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_r <= cmd;
    end
    infl_row_r  <= row_r;
    infl_eot_r  <= dev_end;
    infl_last_r <= dev_end && row_end;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[mem_addr] <= word_new;
    end
    if (rd_en) begin
      rd_data_r <= mem[mem_addr];
      rd_vld_r  <= vld_r[mem_addr];
    end
  end

  assign word_old = rd_vld_r ? rd_data_r : '0;

  always_comb begin
    word_new = word_old;
    for (int r = 0; r < 8; r++) begin
      word_new[r*8 + int'(cmd_r.bit_pos)] = cmd_r.value[7-r];
    end
  end

  assign hit = cmd_r.all_hit || (4'(dev_r) == 4'(cmd_r.target));

  always_comb begin
    frm_item.frame_reg       = hit ? cmd_r.hit_reg : lmcfg_pkg::ADDR_NOOP;
    frm_item.frame_data      = hit ? cmd_r.value : 8'h00;
    frm_item.end_of_transfer = dev_end;
    frm_item.last            = dev_end;
  end

  always_comb begin
    if (infl_r) begin
      ob_din.frame_reg       = {1'b0, infl_row_r} + lmcfg_pkg::ADDR_ROW0;
      ob_din.frame_data      = lmcfg_pkg::flip8(word_old[infl_row_r*8 +: 8]);
      ob_din.end_of_transfer = infl_eot_r;
      ob_din.last            = infl_last_r;
    end else begin
      ob_din = frm_item;
    end
  end

  assign ob_wr     = infl_r || frm_emit;
  assign ob_rd     = out_pop && !out_empty;
  assign out_empty = (ob_cnt_r == 3'd0);
  assign out_item  = ob_mem[ob_rp_r];

  always_ff @(posedge clk) begin
    if (ob_wr) begin
      ob_mem[ob_wp_r] <= ob_din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_wp_r  <= '0;
      ob_rp_r  <= '0;
      ob_cnt_r <= '0;
    end else begin
      if (ob_wr) begin
        ob_wp_r <= ob_wp_r + 2'd1;
      end
      if (ob_rd) begin
        ob_rp_r <= ob_rp_r + 2'd1;
      end
      ob_cnt_r <= ob_cnt_r + 3'(ob_wr) - 3'(ob_rd);
    end
  end

`ifndef SYNTHESIS
  a_ob_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ob_cnt_r <= OB_DEPTH) else $error("result buffer count out of range");
  a_ob_room: assert property (@(posedge clk) disable iff (!rst_n)
    (ob_wr && !ob_rd) |-> (ob_cnt_r < OB_DEPTH)) else $error("result buffer overrun");
  a_infl_src: assert property (@(posedge clk) disable iff (!rst_n)
    infl_r |-> ($past(state_r) == lmcfg_pkg::ST_ROWS)) else $error("stray store read");
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(infl_r && frm_emit)) else $error("two frame sources at once");
`endif

endmodule

// File: sv/led_matrix_chain_frame_generator_unit.sv
// Top level of the LED matrix chain frame generator.
// Holds the chain length register and joins the front and back ends.
// Depends on lmcfg_pkg, lmcfg_front and lmcfg_back.

// Items enter a two-deep command queue and are carried out one at a time.
// Flush and clear produce one frame per cycle while the result buffer has
// room, from the single read port of the shadow store, the last frame landing
// in the buffer in the cycle after its read; write_row, command_all and
// set_intensity give one frame per device, set_column reads and writes back
// one store word, and unused opcodes and columns beyond the chain are
// dropped. The sequencer holds while the result buffer is full. The store
// resets through per-device valid bits, so there is no clearing pass. A
// four-deep result buffer lets the sequencer run ahead of the consumer.
module led_matrix_chain_frame_generator_unit #(
  parameter int MAX_DEVICES = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  lmcfg_pkg::in_item_t   in_item,
  output logic                  out_empty,
  input  logic                  out_pop,
  output lmcfg_pkg::out_item_t  out_item,
  input  logic                  cfg_we,
  input  logic [3:0]            cfg_wdata
);

  localparam int CNT_W = $clog2(MAX_DEVICES + 1);
  localparam int DEV_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
  localparam logic [3:0] MAX_DC = 4'(MAX_DEVICES);

  logic [3:0]         dc_r;
  logic [CNT_W-1:0]   chain_n;
  lmcfg_pkg::cmd_hs_t cmd_hs;
  lmcfg_pkg::cmd_t    cmd;
  logic               cmd_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r <= 4'd4;
    end else if (cfg_we) begin
      dc_r <= cfg_wdata;
    end
  end

  always_comb begin
    priority if (dc_r == 4'd0) begin
      chain_n = CNT_W'(1);
    end else if (dc_r > MAX_DC) begin
      chain_n = CNT_W'(MAX_DEVICES);
    end else begin
      chain_n = CNT_W'(dc_r);
    end
  end

  lmcfg_front #(
    .CNT_W (CNT_W)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_item  (in_item),
    .chain_n  (chain_n),
    .cmd_hs_o (cmd_hs),
    .cmd_pop  (cmd_pop),
    .cmd      (cmd)
  );

  lmcfg_back #(
    .MAX_DEVICES (MAX_DEVICES),
    .CNT_W       (CNT_W),
    .DEV_W       (DEV_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .chain_n   (chain_n),
    .cmd_hs_i  (cmd_hs),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule
